// ===== rtl/bpst_pkg.sv =====
// ----------------------------------------------------------------------------
// bpst_pkg
// Shared types and constants for the bounded priority status table.
// ----------------------------------------------------------------------------
package bpst_pkg;

	localparam int CAPACITY = 8;
	localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CNT_W    = $clog2(CAPACITY + 1);

	localparam int FUNC_W  = 2;
	localparam int ID_W    = 32;
	localparam int PRI_W   = 8;
	localparam int GEN_W   = 64;
	localparam int COUNT_W = 4;
	localparam int CUR_W   = 3;

	localparam int IN_W  = 48;
	localparam int OUT_W = 216;

	localparam logic [FUNC_W-1:0] FUNC_ENQ     = 2'd0;
	localparam logic [FUNC_W-1:0] FUNC_NEXT    = 2'd1;
	localparam logic [FUNC_W-1:0] FUNC_PREV    = 2'd2;
	localparam logic [FUNC_W-1:0] FUNC_DISMISS = 2'd3;

	typedef struct packed {
		logic [GEN_W-1:0] gen;
		logic [PRI_W-1:0] pri;
		logic [ID_W-1:0]  id;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

	typedef struct packed {
		logic             re;
		logic [IDX_W-1:0] raddr;
		logic             we;
		logic [IDX_W-1:0] waddr;
		entry_t           wdata;
	} mem_req_t;

	typedef struct packed {
		logic               accepted;
		logic [GEN_W-1:0]   new_generation;
		logic               evicted_valid;
		logic [ID_W-1:0]    evicted_id;
		logic [COUNT_W-1:0] count;
		logic [CUR_W-1:0]   cursor_index;
		entry_t             cur;
	} result_t;

endpackage

// ===== rtl/bounded_priority_status_table_core.sv =====
// ----------------------------------------------------------------------------
// bounded_priority_status_table_core
// Priority-ordered status table with cursor, held in one entry RAM.
// ----------------------------------------------------------------------------
// Each request yields one result. The entry RAM has one read and one write
// per cycle: it is scanned, shifted for removal and shifted again for
// insertion, one entry per cycle. A held-off output stalls the sequencer.
// A new request is taken once the previous result sits in the output
// register.
module bounded_priority_status_table_core (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        s_tvalid,
	output logic                        s_tready,
	// func[1:0], status_id[33:2], priority_req[41:34], content_ok[42], zero pad
	input  logic [bpst_pkg::IN_W-1:0]   s_tdata,
	output logic                        m_tvalid,
	input  logic                        m_tready,
	// accepted[0], new_generation[64:1], evicted_valid[65], evicted_id[97:66],
	// count[101:98], cursor_index[104:102], cursor_id[136:105],
	// cursor_priority[144:137], cursor_generation[208:145], zero pad
	output logic [bpst_pkg::OUT_W-1:0]  m_tdata
);
	import bpst_pkg::*;

	mem_req_t   mem;
	logic [ENTRY_W-1:0] rdata_raw;
	entry_t     rdata;
	logic       res_valid, res_take;
	result_t    res;
	logic       m_tvalid_q;
	logic [OUT_W-1:0] m_tdata_q;

	assign rdata = entry_t'(rdata_raw);

	bpst_ram #(
		.WIDTH (ENTRY_W),
		.DEPTH (CAPACITY)
	) u_ram (
		.clk   (clk),
		.re    (mem.re),
		.raddr (mem.raddr),
		.rdata (rdata_raw),
		.we    (mem.we),
		.waddr (mem.waddr),
		.wdata (mem.wdata)
	);

	bpst_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.req_valid    (s_tvalid),
		.req_ready    (s_tready),
		.func         (s_tdata[1:0]),
		.status_id    (s_tdata[33:2]),
		.priority_req (s_tdata[41:34]),
		.content_ok   (s_tdata[42]),
		.mem          (mem),
		.rdata        (rdata),
		.res_valid    (res_valid),
		.res          (res),
		.res_take     (res_take)
	);

	assign res_take = !m_tvalid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (res_take) begin
			m_tvalid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && res_take) begin
			m_tdata_q <= {7'd0, res.cur.gen, res.cur.pri, res.cur.id,
				res.cursor_index, res.count, res.evicted_id, res.evicted_valid,
				res.new_generation, res.accepted};
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
endmodule

// ===== rtl/bpst_ram.sv =====
// ----------------------------------------------------------------------------
// bpst_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module bpst_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 8
) (
	input  logic                                    clk,
	input  logic                                    re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                        rdata,
	input  logic                                    we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                        wdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule

// ===== rtl/bpst_ctrl.sv =====
// ----------------------------------------------------------------------------
// bpst_ctrl
// Sequencer: scans, removes and inserts table entries through the RAM.
// ----------------------------------------------------------------------------
module bpst_ctrl (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      req_valid,
	output logic                      req_ready,
	input  logic [bpst_pkg::FUNC_W-1:0] func,
	input  logic [bpst_pkg::ID_W-1:0]   status_id,
	input  logic [bpst_pkg::PRI_W-1:0]  priority_req,
	input  logic                      content_ok,
	output bpst_pkg::mem_req_t        mem,
	input  bpst_pkg::entry_t          rdata,
	output logic                      res_valid,
	output bpst_pkg::result_t         res,
	input  logic                      res_take
);
	import bpst_pkg::*;

	localparam logic [3:0] ST_IDLE = 4'd0;
	localparam logic [3:0] ST_SCAN = 4'd1;
	localparam logic [3:0] ST_REMI = 4'd2;
	localparam logic [3:0] ST_REM  = 4'd3;
	localparam logic [3:0] ST_INSI = 4'd4;
	localparam logic [3:0] ST_INS  = 4'd5;
	localparam logic [3:0] ST_INSL = 4'd6;
	localparam logic [3:0] ST_RD   = 4'd7;
	localparam logic [3:0] ST_RDW  = 4'd8;

	logic [3:0]        state_q, state_d;
	logic [FUNC_W-1:0] func_q, func_d;
	logic [ID_W-1:0]   id_q, id_d;
	logic [PRI_W-1:0]  pri_q, pri_d;
	logic [CNT_W-1:0]  count_q, count_d;
	logic [IDX_W-1:0]  cursor_q, cursor_d;
	logic [GEN_W-1:0]  stamp_q, stamp_d;
	logic [IDX_W-1:0]  ptr_q, ptr_d;
	logic [IDX_W-1:0]  wa_q, wa_d;
	logic              found_q, found_d;
	logic [IDX_W-1:0]  same_q, same_d;
	logic [IDX_W-1:0]  wi_q, wi_d;
	logic [PRI_W-1:0]  wpri_q, wpri_d;
	logic [GEN_W-1:0]  wgen_q, wgen_d;
	logic [ID_W-1:0]   wid_q, wid_d;
	logic              acc_q, acc_d;
	logic [GEN_W-1:0]  genout_q, genout_d;
	logic              ev_q, ev_d;
	logic [ID_W-1:0]   evid_q, evid_d;

	logic [CNT_W-1:0] ptr_ext, cur_ext, cnt_dec;
	logic             hit, better, gt;

	assign ptr_ext = CNT_W'(ptr_q);
	assign cur_ext = CNT_W'(cursor_q);
	assign cnt_dec = count_q - CNT_W'(1);

	always_comb begin
		state_d  = state_q;
		func_d   = func_q;
		id_d     = id_q;
		pri_d    = pri_q;
		count_d  = count_q;
		cursor_d = cursor_q;
		stamp_d  = stamp_q;
		ptr_d    = ptr_q;
		wa_d     = wa_q;
		found_d  = found_q;
		same_d   = same_q;
		wi_d     = wi_q;
		wpri_d   = wpri_q;
		wgen_d   = wgen_q;
		wid_d    = wid_q;
		acc_d    = acc_q;
		genout_d = genout_q;
		ev_d     = ev_q;
		evid_d   = evid_q;
		mem       = '0;
		req_ready = 1'b0;
		res_valid = 1'b0;
		hit    = !found_q && (rdata.id == id_q);
		better = (ptr_q == '0) || (rdata.pri > wpri_q) ||
			((rdata.pri == wpri_q) && (rdata.gen < wgen_q));
		gt     = (rdata.pri > pri_q) || ((rdata.pri == pri_q) && (rdata.gen > stamp_q));

		case (state_q)
			ST_IDLE: begin
				req_ready = 1'b1;
				if (req_valid) begin
					func_d   = func;
					id_d     = status_id;
					pri_d    = priority_req;
					acc_d    = 1'b0;
					genout_d = '0;
					ev_d     = 1'b0;
					evid_d   = '0;
					found_d  = 1'b0;
					state_d  = ST_RD;
					case (func)
						FUNC_ENQ: begin
							if (status_id != '0 && content_ok) begin
								if (count_q == '0) begin
									state_d = ST_INSI;
								end else begin
									mem.re    = 1'b1;
									mem.raddr = '0;
									ptr_d     = '0;
									state_d   = ST_SCAN;
								end
							end
						end
						FUNC_NEXT: begin
							if (count_q != '0) begin
								cursor_d = (cur_ext + CNT_W'(1) >= count_q) ? '0
									: cursor_q + IDX_W'(1);
							end
						end
						FUNC_PREV: begin
							if (count_q != '0) begin
								cursor_d = (cursor_q == '0 || cur_ext > count_q)
									? IDX_W'(cnt_dec) : cursor_q - IDX_W'(1);
							end
						end
						default: begin
							if (count_q != '0) begin
								ptr_d   = cursor_q;
								state_d = ST_REMI;
							end
						end
					endcase
				end
			end
			ST_SCAN: begin
				if (hit) begin
					found_d = 1'b1;
					same_d  = ptr_q;
				end
				if (better) begin
					wi_d   = ptr_q;
					wpri_d = rdata.pri;
					wgen_d = rdata.gen;
					wid_d  = rdata.id;
				end
				if (ptr_ext == cnt_dec) begin
					if (found_d) begin
						ptr_d   = same_d;
						state_d = ST_REMI;
					end else if (count_q == CNT_W'(CAPACITY)) begin
						if (pri_q >= wpri_d) begin
							state_d = ST_RD;
						end else begin
							ev_d    = 1'b1;
							evid_d  = wid_d;
							ptr_d   = wi_d;
							state_d = ST_REMI;
						end
					end else begin
						state_d = ST_INSI;
					end
				end else begin
					mem.re    = 1'b1;
					mem.raddr = ptr_q + IDX_W'(1);
					ptr_d     = ptr_q + IDX_W'(1);
				end
			end
			ST_REMI, ST_REM: begin
				if (state_q == ST_REM) begin
					mem.we    = 1'b1;
					mem.waddr = ptr_q;
					mem.wdata = rdata;
				end
				if (state_q == ST_REMI && ptr_ext + CNT_W'(1) < count_q) begin
					mem.re    = 1'b1;
					mem.raddr = IDX_W'(ptr_ext + CNT_W'(1));
					state_d   = ST_REM;
				end else if (state_q == ST_REM && ptr_ext + CNT_W'(2) < count_q) begin
					mem.re    = 1'b1;
					mem.raddr = IDX_W'(ptr_ext + CNT_W'(2));
					ptr_d     = ptr_q + IDX_W'(1);
				end else begin
					count_d = cnt_dec;
					if (func_q == FUNC_ENQ) begin
						state_d = ST_INSI;
					end else begin
						if (cnt_dec == '0) begin
							cursor_d = '0;
						end else if (cur_ext >= cnt_dec) begin
							cursor_d = IDX_W'(cnt_dec - CNT_W'(1));
						end
						state_d = ST_RD;
					end
				end
			end
			ST_INSI: begin
				if (count_q == '0) begin
					wa_d    = '0;
					state_d = ST_INSL;
				end else begin
					mem.re    = 1'b1;
					mem.raddr = IDX_W'(cnt_dec);
					ptr_d     = IDX_W'(cnt_dec);
					state_d   = ST_INS;
				end
			end
			ST_INS: begin
				if (gt) begin
					mem.we    = 1'b1;
					mem.waddr = IDX_W'(ptr_ext + CNT_W'(1));
					mem.wdata = rdata;
					if (ptr_q == '0) begin
						wa_d    = '0;
						state_d = ST_INSL;
					end else begin
						mem.re    = 1'b1;
						mem.raddr = ptr_q - IDX_W'(1);
						ptr_d     = ptr_q - IDX_W'(1);
					end
				end else begin
					wa_d    = IDX_W'(ptr_ext + CNT_W'(1));
					state_d = ST_INSL;
				end
			end
			ST_INSL: begin
				mem.we        = 1'b1;
				mem.waddr     = wa_q;
				mem.wdata.gen = stamp_q;
				mem.wdata.pri = pri_q;
				mem.wdata.id  = id_q;
				count_d  = count_q + CNT_W'(1);
				stamp_d  = stamp_q + GEN_W'(1);
				cursor_d = '0;
				acc_d    = 1'b1;
				genout_d = stamp_q;
				state_d  = ST_RD;
			end
			ST_RD: begin
				mem.re    = (count_q != '0);
				mem.raddr = cursor_q;
				state_d   = ST_RDW;
			end
			ST_RDW: begin
				res_valid = 1'b1;
				if (res_take) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_comb begin
		res.accepted       = acc_q;
		res.new_generation = genout_q;
		res.evicted_valid  = ev_q;
		res.evicted_id     = evid_q;
		res.count          = COUNT_W'(count_q);
		res.cursor_index   = CUR_W'(cursor_q);
		res.cur            = (count_q != '0) ? rdata : '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			count_q  <= '0;
			cursor_q <= '0;
			stamp_q  <= '0;
			found_q  <= 1'b0;
			acc_q    <= 1'b0;
			ev_q     <= 1'b0;
		end else begin
			state_q  <= state_d;
			count_q  <= count_d;
			cursor_q <= cursor_d;
			stamp_q  <= stamp_d;
			found_q  <= found_d;
			acc_q    <= acc_d;
			ev_q     <= ev_d;
		end
	end

	always_ff @(posedge clk) begin
		func_q   <= func_d;
		id_q     <= id_d;
		pri_q    <= pri_d;
		ptr_q    <= ptr_d;
		wa_q     <= wa_d;
		same_q   <= same_d;
		wi_q     <= wi_d;
		wpri_q   <= wpri_d;
		wgen_q   <= wgen_d;
		wid_q    <= wid_d;
		genout_q <= genout_d;
		evid_q   <= evid_d;
	end

`ifndef NO_ASSERTIONS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(CAPACITY))
		else $error("entry count above capacity");

	a_cursor_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE && count_q != '0) |-> (cur_ext < count_q))
		else $error("cursor beyond last entry");

	a_cursor_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE && count_q == '0) |-> (cursor_q == '0))
		else $error("cursor not zero on empty table");

	a_stamp_step: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_INSL) |=> (stamp_q == $past(stamp_q) + GEN_W'(1)))
		else $error("stamp did not advance on insert");

	a_no_write_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE || state_q == ST_RDW) |-> !mem.we)
		else $error("table write outside an update");
`endif
endmodule

// ===== test/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Drives the priority status table with directed and random requests, predicts
// each result from an own model of the ordered table and cursor, and checks.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
	import bpst_pkg::*;

	localparam int CYCLE_LIMIT = 400000;

	typedef struct packed {
		logic [1:0]  func;
		logic [31:0] status_id;
		logic [7:0]  priority_req;
		logic        content_ok;
	} request_t;

	typedef struct packed {
		logic        accepted;
		logic [63:0] new_generation;
		logic        evicted_valid;
		logic [31:0] evicted_id;
		logic [3:0]  count;
		logic [2:0]  cursor_index;
		logic [31:0] cursor_id;
		logic [7:0]  cursor_priority;
		logic [63:0] cursor_generation;
	} status_t;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              s_tvalid = 1'b0;
	logic              s_tready;
	logic [IN_W-1:0]   s_tdata = '0;
	logic              m_tvalid;
	logic              m_tready = 1'b0;
	logic [OUT_W-1:0]  m_tdata;

	request_t pending_requests[$];
	status_t  expected_status[$];
	int       fail_count = 0;
	int       cycle_count = 0;
	bit       stim_done = 1'b0;
	bit       idle_free = 1'b0;
	bit       sender_pause = 1'b0;
	int       hold_off = 0;

	logic [31:0] tbl_id[CAPACITY];
	logic [7:0]  tbl_pri[CAPACITY];
	logic [63:0] tbl_gen[CAPACITY];
	int          tbl_count = 0;
	int          tbl_cursor = 0;
	logic [63:0] next_stamp = '0;

	bounded_priority_status_table_core u_top (.*);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	function automatic logic [IN_W-1:0] pack_request(request_t r);
		logic [IN_W-1:0] d;
		d = '0;
		d[1:0] = r.func;
		d[33:2] = r.status_id;
		d[41:34] = r.priority_req;
		d[42] = r.content_ok;
		return d;
	endfunction

	task automatic drop_slot(int pos);
		for (int i = pos; i < tbl_count - 1; i++) begin
			tbl_id[i] = tbl_id[i+1];
			tbl_pri[i] = tbl_pri[i+1];
			tbl_gen[i] = tbl_gen[i+1];
		end
		tbl_count--;
	endtask

	task automatic table_step(request_t r);
		status_t s;
		int same, w, pos;
		bit go;
		s = '0;
		if (r.func == FUNC_ENQ) begin
			if (r.status_id != 0 && r.content_ok) begin
				go = 1'b1;
				same = -1;
				for (int i = 0; i < tbl_count; i++)
					if (same < 0 && tbl_id[i] == r.status_id) same = i;
				if (same >= 0) begin
					drop_slot(same);
				end else if (tbl_count >= CAPACITY) begin
					w = 0;
					for (int i = 1; i < tbl_count; i++)
						if (tbl_pri[i] > tbl_pri[w] ||
						    (tbl_pri[i] == tbl_pri[w] && tbl_gen[i] < tbl_gen[w])) w = i;
					if (r.priority_req >= tbl_pri[w]) begin
						go = 1'b0;
					end else begin
						s.evicted_valid = 1'b1;
						s.evicted_id = tbl_id[w];
						drop_slot(w);
					end
				end
				if (go) begin
					pos = 0;
					while (pos < tbl_count && !(tbl_pri[pos] > r.priority_req ||
					       (tbl_pri[pos] == r.priority_req && tbl_gen[pos] > next_stamp)))
						pos++;
					for (int i = tbl_count; i > pos; i--) begin
						tbl_id[i] = tbl_id[i-1];
						tbl_pri[i] = tbl_pri[i-1];
						tbl_gen[i] = tbl_gen[i-1];
					end
					tbl_id[pos] = r.status_id;
					tbl_pri[pos] = r.priority_req;
					tbl_gen[pos] = next_stamp;
					tbl_count++;
					s.accepted = 1'b1;
					s.new_generation = next_stamp;
					next_stamp = next_stamp + 64'd1;
					tbl_cursor = 0;
				end
			end
		end else if (r.func == FUNC_NEXT) begin
			if (tbl_count != 0) tbl_cursor = (tbl_cursor + 1 >= tbl_count) ? 0 : tbl_cursor + 1;
		end else if (r.func == FUNC_PREV) begin
			if (tbl_count != 0)
				tbl_cursor = (tbl_cursor == 0 || tbl_cursor > tbl_count) ? tbl_count - 1
					: tbl_cursor - 1;
		end else begin
			if (tbl_count != 0) begin
				drop_slot(tbl_cursor);
				if (tbl_count == 0) tbl_cursor = 0;
				else if (tbl_cursor >= tbl_count) tbl_cursor = tbl_count - 1;
			end
		end
		s.count = tbl_count[3:0];
		s.cursor_index = tbl_cursor[2:0];
		if (tbl_count != 0 && tbl_cursor < tbl_count) begin
			s.cursor_id = tbl_id[tbl_cursor];
			s.cursor_priority = tbl_pri[tbl_cursor];
			s.cursor_generation = tbl_gen[tbl_cursor];
		end
		expected_status = {expected_status, s};
	endtask

	task automatic add_req(logic [1:0] f, logic [31:0] id, logic [7:0] p, logic ok);
		request_t r;
		r.func = f;
		r.status_id = id;
		r.priority_req = p;
		r.content_ok = ok;
		pending_requests = {pending_requests, r};
	endtask

	function automatic logic [31:0] pick_id();
		case ($urandom_range(0, 9))
			0: return $urandom();
			1: return 32'hFFFF_FFF0 + $urandom_range(0, 15);
			2: return 32'd0;
			default: return $urandom_range(1, 14);
		endcase
	endfunction

	function automatic logic [7:0] pick_pri();
		return ($urandom_range(0, 3) == 0) ? 8'($urandom()) : 8'($urandom_range(0, 5));
	endfunction

	// driver
	always @(posedge clk) begin
		if (arst_n) begin
			if (s_tvalid && s_tready) begin
				table_step(request_t'({s_tdata[1:0], s_tdata[33:2], s_tdata[41:34],
					s_tdata[42]}));
			end
			if (!s_tvalid || s_tready) begin
				if (pending_requests.size() != 0 && !sender_pause &&
				    (idle_free || $urandom_range(0, 99) >= 10)) begin
					s_tvalid <= 1'b1;
					s_tdata <= pack_request(pending_requests.pop_front());
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// monitor
	always @(posedge clk) begin
		status_t got, exp;
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				got = {m_tdata[0], m_tdata[64:1], m_tdata[65], m_tdata[97:66],
					m_tdata[101:98], m_tdata[104:102], m_tdata[136:105],
					m_tdata[144:137], m_tdata[208:145]};
				if (expected_status.size() == 0) begin
					$error("unexpected result %h", got);
					fail_count++;
				end else begin
					exp = expected_status.pop_front();
					if (got.accepted !== exp.accepted) begin
						$error("accepted exp %h got %h", exp.accepted, got.accepted); fail_count++;
					end
					if (got.new_generation !== exp.new_generation) begin
						$error("new_generation exp %h got %h", exp.new_generation,
							got.new_generation); fail_count++;
					end
					if (got.evicted_valid !== exp.evicted_valid) begin
						$error("evicted_valid exp %h got %h", exp.evicted_valid,
							got.evicted_valid); fail_count++;
					end
					if (got.evicted_id !== exp.evicted_id) begin
						$error("evicted_id exp %h got %h", exp.evicted_id, got.evicted_id);
						fail_count++;
					end
					if (got.count !== exp.count) begin
						$error("count exp %h got %h", exp.count, got.count); fail_count++;
					end
					if (got.cursor_index !== exp.cursor_index) begin
						$error("cursor_index exp %h got %h", exp.cursor_index,
							got.cursor_index); fail_count++;
					end
					if (got.cursor_id !== exp.cursor_id) begin
						$error("cursor_id exp %h got %h", exp.cursor_id, got.cursor_id);
						fail_count++;
					end
					if (got.cursor_priority !== exp.cursor_priority) begin
						$error("cursor_priority exp %h got %h", exp.cursor_priority,
							got.cursor_priority); fail_count++;
					end
					if (got.cursor_generation !== exp.cursor_generation) begin
						$error("cursor_generation exp %h got %h", exp.cursor_generation,
							got.cursor_generation); fail_count++;
					end
				end
			end
			if (hold_off > 0) begin
				hold_off <= hold_off - 1;
				m_tready <= 1'b0;
			end else begin
				m_tready <= idle_free || $urandom_range(0, 99) >= 10;
			end
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("tb_top: FAIL");
			$finish;
		end
	end

	initial begin
		logic [1:0] f;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		// empty-table moves and dismiss, rejects
		add_req(FUNC_NEXT, 32'd0, 8'd0, 1'b0);
		add_req(FUNC_PREV, 32'hFFFF_FFFF, 8'hFF, 1'b1);
		add_req(FUNC_DISMISS, 32'd5, 8'd1, 1'b1);
		add_req(FUNC_ENQ, 32'd0, 8'd3, 1'b1);
		add_req(FUNC_ENQ, 32'd7, 8'd3, 1'b0);
		// fill, replace, evict, reject when full
		for (int i = 1; i <= 8; i++) add_req(FUNC_ENQ, 32'(i), 8'(i % 3 + 1), 1'b1);
		add_req(FUNC_ENQ, 32'hFFFF_FFFF, 8'hFF, 1'b1);
		add_req(FUNC_ENQ, 32'd4, 8'd0, 1'b1);
		add_req(FUNC_ENQ, 32'hFFFF_FFFF, 8'd0, 1'b1);
		add_req(FUNC_ENQ, 32'hAAAA_5555, 8'd3, 1'b1);
		add_req(FUNC_PREV, 32'd0, 8'd0, 1'b0);
		add_req(FUNC_DISMISS, 32'd0, 8'd0, 1'b0);
		add_req(FUNC_NEXT, 32'd0, 8'd0, 1'b0);
		add_req(FUNC_NEXT, 32'd0, 8'd0, 1'b0);
		for (int i = 0; i < 8; i++) add_req(FUNC_DISMISS, 32'd0, 8'd0, 1'b0);
		wait (pending_requests.size() == 0);

		// hold the receiver off while requests keep coming
		for (int i = 0; i < 40; i++) add_req(2'($urandom()), pick_id(), pick_pri(), 1'b1);
		@(posedge clk);
		hold_off <= 300;
		wait (pending_requests.size() == 0);

		// pause the sender until every result is back
		sender_pause = 1'b1;
		wait (expected_status.size() == 0 && !s_tvalid);
		sender_pause = 1'b0;

		for (int i = 0; i < 860; i++) begin
			f = ($urandom_range(0, 1) == 0) ? FUNC_ENQ : 2'($urandom());
			add_req(f, pick_id(), pick_pri(), $urandom_range(0, 7) != 0);
			if (i == 300) begin
				idle_free = 1'b1;
				wait (pending_requests.size() == 0);
			end
			if (i == 500) idle_free = 1'b0;
		end
		wait (pending_requests.size() == 0);
		@(posedge clk);
		wait (!s_tvalid && expected_status.size() == 0);
		repeat (100) @(posedge clk);
		if (fail_count == 0 && expected_status.size() == 0) begin
			$display("tb_top: PASS");
		end else begin
			$display("tb_top: FAIL");
		end
		$finish;
	end

endmodule

// ===== files.f =====
rtl/bpst_pkg.sv
rtl/bpst_ram.sv
rtl/bpst_ctrl.sv
rtl/bounded_priority_status_table_core.sv
test/tb_top.sv
